// ===== hw/rtl/lau_pkg.sv =====
`default_nettype none
package lau_pkg;

    localparam int ROW_W         = 16;
    localparam int GEN_W         = 11;
    localparam int MAX_GEN_W     = 10;
    localparam int IDX_OUT_W     = 4;
    localparam int GRID_SIDE_DEF = 16;

    localparam logic [MAX_GEN_W-1:0] MAX_GEN_RESET = MAX_GEN_W'(10);

    // B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_RUN  = 3'b010,
        S_EMIT = 3'b100
    } lau_state_t;

    // columns 1 .. side-2 that fit in a row word
    function automatic logic [ROW_W-1:0] interior_mask(input int side);
        logic [ROW_W-1:0] m;
        m = '0;
        for (int c = 0; c < ROW_W; c++) begin
            m[c] = (c >= 1) && (c <= side - 2);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lau_row_cell.sv =====
`default_nettype none
module lau_row_cell (
    input  wire logic                      clk,
    input  wire logic                      shift_en,
    input  wire logic [lau_pkg::ROW_W-1:0] d,
    output logic      [lau_pkg::ROW_W-1:0] q
);
    import lau_pkg::*;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    assign row_next = shift_en ? d : row_reg;

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign q = row_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/lau_row_rule.sv =====
`default_nettype none
module lau_row_rule (
    input  wire logic [lau_pkg::ROW_W-1:0] above,
    input  wire logic [lau_pkg::ROW_W-1:0] mid,
    input  wire logic [lau_pkg::ROW_W-1:0] below,
    input  wire logic [lau_pkg::ROW_W-1:0] mask,
    output logic      [lau_pkg::ROW_W-1:0] next_row
);
    import lau_pkg::*;

    // zero padding on both sides of each row
    logic [ROW_W+1:0] a_ext;
    logic [ROW_W+1:0] m_ext;
    logic [ROW_W+1:0] b_ext;
    logic [3:0]       cnt [ROW_W];
    logic [ROW_W-1:0] alive;

    assign a_ext = {1'b0, above, 1'b0};
    assign m_ext = {1'b0, mid, 1'b0};
    assign b_ext = {1'b0, below, 1'b0};

    always_comb
    begin
        for (int c = 0; c < ROW_W; c++) begin
            cnt[c] = 4'(a_ext[c]) + 4'(a_ext[c+1]) + 4'(a_ext[c+2])
                   + 4'(m_ext[c]) + 4'(m_ext[c+2])
                   + 4'(b_ext[c]) + 4'(b_ext[c+1]) + 4'(b_ext[c+2]);
            alive[c] = (cnt[c] == BIRTH_COUNT)
                    || (mid[c] && (cnt[c] == SURVIVE_COUNT));
        end
    end

    assign next_row = alive & mask;

endmodule
`default_nettype wire

// ===== hw/rtl/life_automaton_until_stable_top.sv =====
`default_nettype none
// Game of life (B3/S23) on a GRID_SIDE x GRID_SIDE grid with dead borders.
// Rows come in top first, one request per cycle while loading, and are held
// in a chain of row cells that shifts toward the head. After the last row,
// each generation streams the chain once through the single rule stage at
// its head, one row per cycle, two generations per round. Iteration ends
// after a round whose two generations match, or after the round in which the
// generation count reaches max_generations (at least one round). The final
// grid then leaves one row per request. No input is taken while computing or
// emitting. max_generations is to be written only while idle; the block
// does not enforce this.
module life_automaton_until_stable_top #(
    parameter int GRID_SIDE = lau_pkg::GRID_SIDE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lau_pkg::ROW_W-1:0]     row_cells,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [lau_pkg::ROW_W-1:0]     out_row_cells,
    output logic      [lau_pkg::IDX_OUT_W-1:0] out_row_index,
    output logic                               last_row,
    output logic      [lau_pkg::GEN_W-1:0]     generations_run,
    output logic                               reached_stable,
    input  wire logic                          max_generations_we,
    input  wire logic [lau_pkg::MAX_GEN_W-1:0] max_generations
);
    import lau_pkg::*;

    localparam int IDX_W = $clog2(GRID_SIDE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIDE - 1);
    localparam logic [ROW_W-1:0] MASK = interior_mask(GRID_SIDE);

    lau_state_t             state_reg, state_next;
    logic [IDX_W-1:0]       row_cnt_reg, row_cnt_next;
    logic [GEN_W-1:0]       gen_cnt_reg, gen_cnt_next;
    logic                   phase_reg, phase_next;
    logic                   diff_reg, diff_next;
    logic                   stable_reg, stable_next;
    logic [MAX_GEN_W-1:0]   max_gen_reg, max_gen_next;
    logic [ROW_W-1:0]       above_reg, above_next;

    logic [ROW_W-1:0]       row_q [GRID_SIDE];
    logic [ROW_W-1:0]       tail_d;
    logic                   shift_en;
    logic [ROW_W-1:0]       rule_row;
    logic [ROW_W-1:0]       new_row;
    logic [ROW_W-1:0]       load_row;
    logic                   is_border;
    logic                   row_last;
    logic [GEN_W-1:0]       gen_inc;
    logic                   round_diff;
    logic                   stop;
    logic                   in_fire;
    logic                   out_fire;

    genvar gi;
    generate
        for (gi = 0; gi < GRID_SIDE; gi++) begin : g_chain
            if (gi == GRID_SIDE - 1) begin : g_tail
                lau_row_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (tail_d),
                    .q        (row_q[gi])
                );
            end else begin : g_body
                lau_row_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .d        (row_q[gi+1]),
                    .q        (row_q[gi])
                );
            end
        end
    endgenerate

    // head of the chain is the row being updated, the next cell is below it
    lau_row_rule u_rule (
        .above    (above_reg),
        .mid      (row_q[0]),
        .below    (row_q[1]),
        .mask     (MASK),
        .next_row (rule_row)
    );

    assign row_last  = (row_cnt_reg == LAST_IDX);
    assign is_border = (row_cnt_reg == '0) || row_last;
    assign new_row   = is_border ? '0 : rule_row;
    assign load_row  = is_border ? '0 : (row_cells & MASK);
    assign tail_d    = (state_reg == S_LOAD) ? load_row : new_row;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_EMIT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign shift_en  = in_fire || (state_reg == S_RUN) || out_fire;

    assign gen_inc    = gen_cnt_reg + GEN_W'(1);
    // second generation of a round differs from the first somewhere
    assign round_diff = diff_reg || (new_row != row_q[0]);
    assign stop       = !round_diff || (gen_inc >= GEN_W'(max_gen_reg));

    always_comb
    begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        gen_cnt_next = gen_cnt_reg;
        phase_next   = phase_reg;
        diff_next    = diff_reg;
        stable_next  = stable_reg;
        above_next   = above_reg;
        max_gen_next = max_generations_we ? max_generations : max_gen_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire) begin
                    row_cnt_next = row_last ? '0 : row_cnt_reg + IDX_W'(1);
                    if (row_last) begin
                        state_next   = S_RUN;
                        gen_cnt_next = '0;
                        phase_next   = 1'b0;
                        diff_next    = 1'b0;
                    end
                end
            end
            S_RUN:
            begin
                above_next   = row_q[0];
                row_cnt_next = row_last ? '0 : row_cnt_reg + IDX_W'(1);
                if (phase_reg) begin
                    diff_next = round_diff;
                end
                if (row_last) begin
                    gen_cnt_next = gen_inc;
                    phase_next   = !phase_reg;
                    diff_next    = 1'b0;
                    if (phase_reg) begin
                        stable_next = !round_diff;
                        if (stop) begin
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (out_fire) begin
                    row_cnt_next = row_last ? '0 : row_cnt_reg + IDX_W'(1);
                    if (row_last) begin
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next   = S_LOAD;
                row_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_LOAD;
            row_cnt_reg <= '0;
            gen_cnt_reg <= '0;
            phase_reg   <= 1'b0;
            diff_reg    <= 1'b0;
            stable_reg  <= 1'b0;
            max_gen_reg <= MAX_GEN_RESET;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            gen_cnt_reg <= gen_cnt_next;
            phase_reg   <= phase_next;
            diff_reg    <= diff_next;
            stable_reg  <= stable_next;
            max_gen_reg <= max_gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        above_reg <= above_next;
    end

    assign out_row_cells   = row_q[0];
    assign out_row_index   = IDX_OUT_W'(row_cnt_reg);
    assign last_row        = row_last;
    assign generations_run = gen_cnt_reg;
    assign reached_stable  = stable_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/lau_checker.sv =====
`default_nettype none
module lau_checker #(
    parameter int GRID_SIDE = lau_pkg::GRID_SIDE_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [lau_pkg::ROW_W-1:0]     out_row_cells,
    input wire logic [lau_pkg::IDX_OUT_W-1:0] out_row_index,
    input wire logic                          last_row,
    input wire logic [lau_pkg::GEN_W-1:0]     generations_run,
    input wire logic                          reached_stable
);
    import lau_pkg::*;

    localparam logic [IDX_OUT_W-1:0] LAST_OUT_IDX = IDX_OUT_W'(GRID_SIDE - 1);

    // no new grid is taken while the old one is still going out
    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while emitting results");

    // whole rounds only, at least one
    a_gen_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (generations_run[0] == 1'b0) && (generations_run != '0))
        else $error("generation count not a positive even number");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_row) |-> (out_row_index == LAST_OUT_IDX))
        else $error("last row flagged at wrong index");

    // rows of one grid follow in order with the same summary fields
    a_row_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_row) |=>
            out_valid
            && (out_row_index == $past(out_row_index) + IDX_OUT_W'(1))
            && (generations_run == $past(generations_run))
            && (reached_stable == $past(reached_stable)))
        else $error("result rows out of sequence");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_row_cells))
        else $error("stalled result changed");

endmodule

bind life_automaton_until_stable_top lau_checker #(.GRID_SIDE(GRID_SIDE)) u_lau_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row_cells      (out_row_cells),
    .out_row_index      (out_row_index),
    .last_row           (last_row),
    .generations_run    (generations_run),
    .reached_stable     (reached_stable)
);
`default_nettype wire

// ===== tb/tb_life_automaton_until_stable_top.sv =====
`default_nettype none
module tb_life_automaton_until_stable_top;

    localparam int SIDE        = lau_pkg::GRID_SIDE_DEF;
    localparam int RAND_GRIDS  = 27;
    localparam int CYCLE_LIMIT = 2000000;

    typedef logic [SIDE-1:0][lau_pkg::ROW_W-1:0] grid_t;

    typedef struct packed {
        logic [lau_pkg::ROW_W-1:0]     cells;
        logic [lau_pkg::IDX_OUT_W-1:0] idx;
        logic                          last;
        logic [lau_pkg::GEN_W-1:0]     gens;
        logic                          stable;
    } row_result_t;

    typedef enum int {
        K_DENSE,
        K_SPARSE,
        K_BLOCKS,
        K_BLINKER,
        K_GLIDER,
        K_UNIFORM
    } grid_kind_t;

    class life_scoreboard;
        localparam logic [lau_pkg::ROW_W-1:0] INNER_COLS = 16'h7FFE;

        grid_t       cur_gen;
        grid_t       next_gen;
        int          rows_seen;
        int          gen_limit;
        int          grids_done;
        int          stable_grids;
        row_result_t final_rows[$];

        function new();
            cur_gen      = '0;
            next_gen     = '0;
            rows_seen    = 0;
            gen_limit    = 10;
            grids_done   = 0;
            stable_grids = 0;
        endfunction

        function void set_limit(int v);
            gen_limit = v;
        endfunction

        function int pending();
            return final_rows.size();
        endfunction

        // one B3/S23 generation, border rows and columns stay dead
        function grid_t advance(grid_t s);
            grid_t d;
            int    n;
            d = '0;
            for (int r = 1; r < SIDE - 1; r++) begin
                for (int c = 1; c < SIDE - 1; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if (dr != 0 || dc != 0)
                                n += int'(s[r+dr][c+dc]);
                        end
                    end
                    d[r][c] = (n == int'(lau_pkg::BIRTH_COUNT)) ||
                              (s[r][c] && n == int'(lau_pkg::SURVIVE_COUNT));
                end
            end
            return d;
        endfunction

        function void note_request(logic [lau_pkg::ROW_W-1:0] row);
            row_result_t res;
            logic        same;
            int          gens;
            if (rows_seen == 0 || rows_seen == SIDE - 1)
                cur_gen[rows_seen] = '0;
            else
                cur_gen[rows_seen] = row & INNER_COLS;
            rows_seen++;
            if (rows_seen < SIDE)
                return;
            rows_seen = 0;
            gens      = 0;
            // rounds of two generations, limit only tested after a whole round
            do begin
                next_gen = advance(cur_gen);
                cur_gen  = advance(next_gen);
                gens += 2;
                same = (cur_gen == next_gen);
            end while (!same && gens < gen_limit);
            grids_done++;
            if (same)
                stable_grids++;
            for (int i = 0; i < SIDE; i++) begin
                res.cells  = cur_gen[i];
                res.idx    = lau_pkg::IDX_OUT_W'(i);
                res.last   = (i == SIDE - 1);
                res.gens   = lau_pkg::GEN_W'(gens);
                res.stable = same;
                final_rows.push_back(res);
            end
        endfunction

        function string check_result(row_result_t got);
            row_result_t want;
            string       msg;
            if (final_rows.size() == 0)
                return $sformatf("row %0d came out with nothing expected", got.idx);
            want = final_rows.pop_front();
            msg  = "";
            if (got.cells !== want.cells)
                msg = {msg, $sformatf(" cells %h want %h", got.cells, want.cells)};
            if (got.idx !== want.idx)
                msg = {msg, $sformatf(" index %0d want %0d", got.idx, want.idx)};
            if (got.last !== want.last)
                msg = {msg, $sformatf(" last %b want %b", got.last, want.last)};
            if (got.gens !== want.gens)
                msg = {msg, $sformatf(" gens %0d want %0d", got.gens, want.gens)};
            if (got.stable !== want.stable)
                msg = {msg, $sformatf(" stable %b want %b", got.stable, want.stable)};
            if (msg != "")
                msg = $sformatf("row %0d:%s", want.idx, msg);
            return msg;
        endfunction
    endclass

    logic                          clk                = 1'b0;
    logic                          rst_n              = 1'b0;
    logic                          in_valid           = 1'b0;
    logic                          in_ready;
    logic [lau_pkg::ROW_W-1:0]     row_cells          = '0;
    logic                          out_valid;
    logic                          out_ready          = 1'b0;
    logic [lau_pkg::ROW_W-1:0]     out_row_cells;
    logic [lau_pkg::IDX_OUT_W-1:0] out_row_index;
    logic                          last_row;
    logic [lau_pkg::GEN_W-1:0]     generations_run;
    logic                          reached_stable;
    logic                          max_generations_we = 1'b0;
    logic [lau_pkg::MAX_GEN_W-1:0] max_generations    = '0;

    life_scoreboard sb;
    int             errors   = 0;
    int             rows_in  = 0;
    int             rows_out = 0;
    int             lim_lo   = 10;
    int             lim_hi   = 10;
    logic           quiet    = 1'b0;

    life_automaton_until_stable_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .row_cells          (row_cells),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .out_row_cells      (out_row_cells),
        .out_row_index      (out_row_index),
        .last_row           (last_row),
        .generations_run    (generations_run),
        .reached_stable     (reached_stable),
        .max_generations_we (max_generations_we),
        .max_generations    (max_generations)
    );

    always #5 clk = ~clk;

    task automatic note_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int gap_len();
        int p;
        if (quiet)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_limit();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 24);
        return $urandom_range(25, 160);
    endfunction

    function automatic grid_t make_grid(input grid_kind_t kind);
        grid_t g;
        int    r0;
        int    c0;
        g = '0;
        case (kind)
            K_DENSE: begin
                for (int i = 0; i < SIDE; i++)
                    g[i] = lau_pkg::ROW_W'($urandom);
            end
            K_SPARSE: begin
                for (int i = 0; i < SIDE; i++)
                    g[i] = lau_pkg::ROW_W'($urandom & $urandom & $urandom);
            end
            K_BLOCKS: begin
                // still lifes spaced apart so they never interact
                for (int rr = 2; rr <= 10; rr += 4) begin
                    for (int cc = 2; cc <= 10; cc += 4) begin
                        if ($urandom_range(0, 1) == 1) begin
                            g[rr][cc +: 2]   = 2'b11;
                            g[rr+1][cc +: 2] = 2'b11;
                        end
                    end
                end
            end
            K_BLINKER: begin
                // period two, never settles, so the limit decides
                r0 = $urandom_range(2, 13);
                c0 = $urandom_range(1, 12);
                g[r0][c0 +: 3] = 3'b111;
            end
            K_GLIDER: begin
                r0 = $urandom_range(1, 11);
                c0 = $urandom_range(1, 11);
                g[r0][c0+1]      = 1'b1;
                g[r0+1][c0+2]    = 1'b1;
                g[r0+2][c0 +: 3] = 3'b111;
            end
            default: begin
                for (int i = 0; i < SIDE; i++)
                    g[i] = {lau_pkg::ROW_W{$urandom_range(0, 1) == 1}};
            end
        endcase
        // junk on border cells, which the block must drop
        g[0]      = lau_pkg::ROW_W'($urandom);
        g[SIDE-1] = lau_pkg::ROW_W'($urandom);
        for (int i = 1; i < SIDE - 1; i++) begin
            g[i][0]      = $urandom_range(0, 1);
            g[i][SIDE-1] = $urandom_range(0, 1);
        end
        return g;
    endfunction

    task automatic send_row(input logic [lau_pkg::ROW_W-1:0] row);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_cells <= row;
        do @(posedge clk); while (!in_ready);
        sb.note_request(row);
        rows_in++;
    endtask

    task automatic send_grid(input grid_t g);
        for (int i = 0; i < SIDE; i++)
            send_row(g[i]);
    endtask

    // hold the sender until the last grid is fully out, then change the limit
    task automatic settle_and_write(input int v);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        max_generations_we <= 1'b1;
        max_generations    <= lau_pkg::MAX_GEN_W'(v);
        @(posedge clk);
        max_generations_we <= 1'b0;
        sb.set_limit(v);
        if (v < lim_lo)
            lim_lo = v;
        if (v > lim_hi)
            lim_hi = v;
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout with %0d rows still expected", sb.pending());
        $display("life_automaton_until_stable_top regression: fail");
        $finish;
    end

    // result side: check every accepted row, stall at random
    initial begin
        int          hold;
        row_result_t got;
        string       msg;
        hold = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got.cells  = out_row_cells;
                got.idx    = out_row_index;
                got.last   = last_row;
                got.gens   = generations_run;
                got.stable = reached_stable;
                msg = sb.check_result(got);
                if (msg != "")
                    note_mismatch(msg);
                rows_out++;
            end
            if (hold != 0) begin
                hold--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                hold = gap_len();
            end
        end
    end

    initial begin
        grid_t      g;
        grid_kind_t kind;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full rows everywhere under the reset limit, borders must be cleared
        for (int i = 0; i < SIDE; i++)
            g[i] = '1;
        send_grid(g);

        // lone block with limit zero: still at the first round, one round only
        settle_and_write(0);
        for (int i = 0; i < SIDE; i++)
            g[i] = 16'h8001;
        g[0]      = '1;
        g[SIDE-1] = '1;
        g[5]      = 16'h8019;
        g[6]      = 16'h8019;
        send_grid(g);

        for (int n = 0; n < RAND_GRIDS; n++) begin
            quiet = ($urandom_range(0, 4) == 0);
            kind  = grid_kind_t'($urandom_range(0, 5));
            if (n == 3) begin
                settle_and_write(1023);
                kind = K_BLINKER;
            end
            else if (n == 14) begin
                settle_and_write(1022);
                kind = K_BLINKER;
            end
            else if (n == 20) begin
                settle_and_write(1);
            end
            else if ($urandom_range(0, 1) == 1) begin
                settle_and_write(pick_limit());
            end
            send_grid(make_grid(kind));
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d grids, %0d rows sent, %0d rows checked, %0d settled to a still life",
                 sb.grids_done, rows_in, rows_out, sb.stable_grids);
        $display("generation limits ranged from %0d to %0d", lim_lo, lim_hi);
        if (errors == 0 && sb.pending() == 0)
            $display("life_automaton_until_stable_top regression: pass");
        else
            $display("life_automaton_until_stable_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
